// File: design/dsfp_pkg.sv
// Package for the dust sensor frame parser.
// Holds frame constants, parser phase codes and the result record type.
// No dependencies.
`default_nettype none

package dsfp_pkg;

	localparam logic [7:0] HDR_FIRST    = 8'h42;
	localparam logic [7:0] HDR_SECOND   = 8'h4D;
	localparam logic [8:0] LEN_LIMIT    = 9'd256;
	localparam logic [8:0] LEN_FALLBACK = 9'd28;
	localparam logic [8:0] SUM_BYTES    = 9'd30;
	localparam logic [8:0] MIN_BODY     = 9'd28;
	localparam logic [8:0] POS_PM1_HI   = 9'd10;
	localparam logic [8:0] POS_PM1_LO   = 9'd11;
	localparam logic [8:0] POS_PM25_HI  = 9'd12;
	localparam logic [8:0] POS_PM25_LO  = 9'd13;
	localparam logic [8:0] POS_PM10_HI  = 9'd14;
	localparam logic [8:0] POS_PM10_LO  = 9'd15;
	localparam logic [8:0] POS_CHK_HI   = 9'd30;
	localparam logic [8:0] POS_CHK_LO   = 9'd31;
	localparam logic [8:0] POS_BODY     = 9'd4;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_HDR2   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_BODY   = 3'd4;

	typedef struct packed {
		logic        valid;
		logic [15:0] pm1_value;
		logic [15:0] pm25_value;
		logic [15:0] pm10_value;
		logic        checksum_ok;
		logic [8:0]  frame_length;
	} frame_result_t;

endpackage

`default_nettype wire

// File: design/dsfp_parser.sv
// Frame parser state machine: header hunt, length, body capture and checksum.
// Consumes one byte per enabled cycle and flags a result on the closing byte.
// Depends on dsfp_pkg.
`default_nettype none

module dsfp_parser (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_en,
	input  wire logic [7:0]             byte_data,
	output dsfp_pkg::frame_result_t     result
);
	import dsfp_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [8:0]  len_q, len_d;
	logic [8:0]  pos_q, pos_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] chk_q, chk_d;
	logic [15:0] pm1_q, pm1_d;
	logic [15:0] pm25_q, pm25_d;
	logic [15:0] pm10_q, pm10_d;
	logic        emit;
	logic [15:0] len_raw;
	logic [9:0]  pos_inc;
	logic [15:0] sum_add;

	assign len_raw = {len_q[7:0], byte_data};
	assign pos_inc = {1'b0, pos_q} + 10'd1;
	assign sum_add = sum_q + {8'd0, byte_data};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		pos_d   = pos_q;
		sum_d   = sum_q;
		chk_d   = chk_q;
		pm1_d   = pm1_q;
		pm25_d  = pm25_q;
		pm10_d  = pm10_q;
		emit    = 1'b0;
		case (phase_q)
			PH_HDR2: begin
				if (byte_data == HDR_SECOND) begin
					sum_d   = sum_add;
					phase_d = PH_LEN_HI;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN_HI: begin
				len_d   = {1'b0, byte_data};
				sum_d   = sum_add;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d   = (len_raw > {7'd0, LEN_LIMIT}) ? LEN_FALLBACK : len_raw[8:0];
				sum_d   = sum_add;
				pos_d   = POS_BODY;
				phase_d = PH_BODY;
				if (len_d == 9'd0) begin
					emit    = 1'b1;
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (pos_q < SUM_BYTES)
					sum_d = sum_add;
				case (pos_q)
					POS_PM1_HI:  pm1_d  = {byte_data, pm1_q[7:0]};
					POS_PM1_LO:  pm1_d  = {pm1_q[15:8], byte_data};
					POS_PM25_HI: pm25_d = {byte_data, pm25_q[7:0]};
					POS_PM25_LO: pm25_d = {pm25_q[15:8], byte_data};
					POS_PM10_HI: pm10_d = {byte_data, pm10_q[7:0]};
					POS_PM10_LO: pm10_d = {pm10_q[15:8], byte_data};
					POS_CHK_HI:  chk_d  = {byte_data, chk_q[7:0]};
					POS_CHK_LO:  chk_d  = {chk_q[15:8], byte_data};
					default: ;
				endcase
				pos_d = pos_inc[8:0];
				if (pos_inc >= ({1'b0, len_q} + 10'd4)) begin
					emit    = 1'b1;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (byte_data == HDR_FIRST) begin
					sum_d   = {8'd0, byte_data};
					chk_d   = 16'd0;
					pm1_d   = 16'd0;
					pm25_d  = 16'd0;
					pm10_d  = 16'd0;
					len_d   = 9'd0;
					pos_d   = 9'd0;
					phase_d = PH_HDR2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q   <= 9'd0;
			pos_q   <= 9'd0;
			sum_q   <= 16'd0;
			chk_q   <= 16'd0;
			pm1_q   <= 16'd0;
			pm25_q  <= 16'd0;
			pm10_q  <= 16'd0;
		end else if (byte_en) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			chk_q   <= chk_d;
			pm1_q   <= pm1_d;
			pm25_q  <= pm25_d;
			pm10_q  <= pm10_d;
		end
	end

	always_comb begin
		result.valid        = byte_en && emit;
		result.pm1_value    = pm1_d;
		result.pm25_value   = pm25_d;
		result.pm10_value   = pm10_d;
		result.checksum_ok  = (sum_d == chk_d) && (len_d >= MIN_BODY);
		result.frame_length = len_d;
	end

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> byte_en)
		else $error("result flagged without a consumed byte");

	a_hunt_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |=> (phase_q == PH_HUNT))
		else $error("parser did not return to hunting after a frame");

	a_ok_needs_full_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.checksum_ok) |-> (result.frame_length >= MIN_BODY))
		else $error("checksum accepted on a short frame");

endmodule

`default_nettype wire

// File: design/dust_sensor_frame_parser_core.sv
// Top level of the dust sensor frame parser: stream ports, input and output registers.
// Instantiates dsfp_parser; depends on dsfp_pkg.
`default_nettype none

// Takes one received sensor byte per transfer and returns one result per frame
// (header 0x42 0x4D, big-endian length, body). A new byte is accepted each cycle
// while the input register is empty or the output register is empty or being taken.
// From the byte closing a frame to its result, the byte passes one input register,
// then the parser's combinational step into the output register.
// checksum_ok is low for frames shorter than 32 bytes or with a bad checksum.
module dust_sensor_frame_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [15:0] pm1_value, [31:16] pm25_value,
	                                         // [47:32] pm10_value, [56:48] frame_length,
	                                         // [63:57] zero
	output logic             m_axis_tuser    // checksum_ok
);
	import dsfp_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          out_valid_q;
	logic [15:0]   pm1_q;
	logic [15:0]   pm25_q;
	logic [15:0]   pm10_q;
	logic          ok_q;
	logic [8:0]    flen_q;
	frame_result_t res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	dsfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (valid_s1 && advance),
		.byte_data (byte_s1),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			pm1_q  <= res.pm1_value;
			pm25_q <= res.pm25_value;
			pm10_q <= res.pm10_value;
			ok_q   <= res.checksum_ok;
			flen_q <= res.frame_length;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, flen_q, pm10_q, pm25_q, pm1_q};
	assign m_axis_tuser  = ok_q;

	a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_result_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |=> out_valid_q)
		else $error("parser result lost before the output register");

	a_held_byte_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte changed");

endmodule

`default_nettype wire
